>>> rtl/icmp4_pkg.sv
// types and constants for the icmpv4 header anomaly checker
// no dependencies
package icmp4_pkg;

  localparam int EvW = 25;

  localparam logic [15:0] MinMtu    = 16'd576;
  localparam logic [12:0] FragMask  = 13'h1FFF;
  localparam logic [15:0] EnumSeq   = 16'd666;
  localparam logic [3:0]  IhlMask   = 4'h0f;
  localparam logic [15:0] MinInner  = 16'd20;
  localparam logic [15:0] AddrLen   = 16'd12;

  localparam logic CfgMask = 1'b0;
  localparam logic CfgCsum = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] outer_dst_addr;
    logic [15:0] outer_total_len;
    logic        outer_has_record_route;
    logic        outer_is_ipv6;
  } in_item_t;

  typedef struct packed {
    logic [EvW-1:0] event_flags;
    logic           accepted;
    logic [3:0]     header_len;
    logic [15:0]    payload_len;
    logic           orig_ports_valid;
    logic [15:0]    orig_src_port;
    logic [15:0]    orig_dst_port;
  } out_item_t;

  // message summary handed from the byte front end to the decoder
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] seq;
    logic [7:0]  ver_ihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] ports;
    logic        csum_ok;
    logic [31:0] dst;
    logic [15:0] otot;
    logic        rr;
    logic        v6;
  } msg_sum_t;

endpackage

>>> rtl/icmp4_front.sv
// byte front end: counts bytes, keeps checksum, captures header fields
// uses icmp4_pkg
module icmp4_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  icmp4_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               in_stall,
  output logic               sum_valid,
  output icmp4_pkg::msg_sum_t sum
);
  import icmp4_pkg::*;

  logic [15:0] byte_index;
  logic [16:0] checksum_sum;
  logic [7:0]  odd_byte_hold;
  logic        odd_pending;
  logic [7:0]  msg_type, msg_code, inner_ver_ihl, inner_protocol;
  logic [15:0] second_word_low, inner_frag_word;
  logic [31:0] inner_ports;

  logic        take, fin;
  logic [7:0]  b;
  logic [7:0]  ver_n;
  logic [15:0] p0;
  logic [31:0] ports_n;
  logic [16:0] s1, s2, fold_in;
  logic [15:0] word;

  assign in_stall = q_full;
  assign take = in_valid && !q_full;
  assign b = in_item.data_byte;
  assign fin = take && in_item.last_byte;

  always_comb begin
    ver_n = (byte_index == 16'd8) ? b : inner_ver_ihl;
    p0 = 16'd8 + {10'd0, ver_n[3:0] & IhlMask, 2'b00};
    ports_n = inner_ports;
    if (byte_index >= 16'd8 && byte_index >= p0 && byte_index < p0 + 16'd4)
      ports_n = {inner_ports[23:0], b};
    word = odd_pending ? {odd_byte_hold, b} : {b, 8'd0};
    fold_in = {1'b0, checksum_sum[15:0]} + {1'b0, word};
    s1 = {16'd0, checksum_sum[16]} + {1'b0, fold_in[15:0]} + {16'd0, fold_in[16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
  end

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      byte_index <= '0; checksum_sum <= '0; odd_byte_hold <= '0; odd_pending <= 1'b0;
      msg_type <= '0; msg_code <= '0; second_word_low <= '0; inner_ver_ihl <= '0;
      inner_frag_word <= '0; inner_protocol <= '0; inner_ports <= '0;
    end else if (take) begin
      if (byte_index != 16'hFFFF) byte_index <= byte_index + 16'd1;
      case (byte_index)
        16'd0:   msg_type <= b;
        16'd1:   msg_code <= b;
        16'd6:   second_word_low[15:8] <= b;
        16'd7:   second_word_low[7:0] <= b;
        16'd8:   inner_ver_ihl <= b;
        16'd14:  inner_frag_word[15:8] <= b;
        16'd15:  inner_frag_word[7:0] <= b;
        16'd17:  inner_protocol <= b;
        default: ;
      endcase
      inner_ports <= ports_n;
      if (odd_pending) begin
        checksum_sum <= {1'b0, s2[15:0]};
        odd_pending <= 1'b0;
      end else begin
        odd_byte_hold <= b;
        odd_pending <= 1'b1;
      end
    end
  end

  // summary of the finished message, captures of the last byte merged in
  always_comb begin
    sum_valid = fin;
    sum.len = (byte_index == 16'hFFFF) ? 16'hFFFF : byte_index + 16'd1;
    sum.msg_type = (byte_index == 16'd0) ? b : msg_type;
    sum.msg_code = (byte_index == 16'd1) ? b : msg_code;
    sum.seq = (byte_index == 16'd6) ? {b, 8'd0} :
              (byte_index == 16'd7) ? {second_word_low[15:8], b} : second_word_low;
    sum.ver_ihl = ver_n;
    sum.frag = (byte_index == 16'd14) ? {b, 8'd0} :
               (byte_index == 16'd15) ? {inner_frag_word[15:8], b} : inner_frag_word;
    sum.proto = (byte_index == 16'd17) ? b : inner_protocol;
    sum.ports = ports_n;
    sum.csum_ok = (s2[15:0] == 16'hFFFF);
    sum.dst = in_item.outer_dst_addr;
    sum.otot = in_item.outer_total_len;
    sum.rr = in_item.outer_has_record_route;
    sum.v6 = in_item.outer_is_ipv6;
  end
endmodule

>>> rtl/icmp4_queue.sv
// two-entry queue of message summaries between front end and decoder
// uses icmp4_pkg
module icmp4_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  icmp4_pkg::msg_sum_t wr_data,
  output logic                full,
  output logic                rd_valid,
  input  logic                rd_en,
  output icmp4_pkg::msg_sum_t rd_data
);
  import icmp4_pkg::*;

  msg_sum_t    mem [2];
  logic        wp, rp;
  logic [1:0]  count;

  assign full = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= '0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !wr_en)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (rst) !rd_valid |-> !rd_en)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> count == $past(count) + 2'd1)
    else $error("queue count slip");
endmodule

>>> rtl/icmp4_decode.sv
// decoder: turns a message summary into the masked result, with output register
// uses icmp4_pkg
module icmp4_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [24:0]          event_enable_mask,
  input  logic                 checksum_check_enable,
  input  logic                 q_valid,
  input  icmp4_pkg::msg_sum_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output icmp4_pkg::out_item_t out_item
);
  import icmp4_pkg::*;

  out_item_t r;
  logic [24:0] ev;
  logic acc;
  logic [3:0] hl;
  logic [15:0] pay, elen, hlen;
  logic [7:0] t, c;
  logic [15:0] seq;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    t = q_data.msg_type; c = q_data.msg_code; seq = q_data.seq;
    ev = '0; acc = 1'b1; hl = 4'd0; pay = '0;
    r = '0;
    hlen = {10'd0, q_data.ver_ihl[3:0] & IhlMask, 2'b00};
    elen = q_data.len - 16'd8;
    if (q_data.len < 16'd4) begin
      ev[0] = 1'b1; acc = 1'b0;
    end else begin
      case (t) inside
        8'd0, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd15, 8'd16:
          if (q_data.len < 16'd8) begin ev[1] = 1'b1; acc = 1'b0; end
        8'd13, 8'd14:
          if (q_data.len < MinInner) begin ev[2] = 1'b1; acc = 1'b0; end
        8'd17, 8'd18:
          if (q_data.len < AddrLen) begin ev[3] = 1'b1; acc = 1'b0; end
        default: ev[4] = 1'b1;
      endcase
    end
    if (acc) begin
      if (checksum_check_enable && !q_data.csum_ok) ev[5] = 1'b1;
      hl = 4'd4;
      if (t == 8'd8) begin
        if (q_data.dst == 32'hFFFFFFFF) ev[13] = 1'b1;
        if (q_data.dst[31:28] == 4'hE) ev[14] = 1'b1;
      end
      if (t == 8'd8 || t == 8'd0) begin
        hl = 4'd8;
      end else if (t == 8'd3 || t == 8'd4 || t == 8'd5 || t == 8'd11 || t == 8'd12) begin
        if (t == 8'd3 && c == 8'd4 && seq < MinMtu) ev[6] = 1'b1;
        hl = 4'd8;
        if (elen < MinInner) ev[7] = 1'b1;
        else if (q_data.ver_ihl[7:4] != 4'd4 && !q_data.v6) ev[8] = 1'b1;
        else if (elen < hlen) ev[9] = 1'b1;
        else if ((q_data.frag[12:0] & FragMask) != 13'd0) ev[10] = 1'b1;
        else if (elen - hlen < 16'd8) ev[11] = 1'b1;
        else begin
          if (q_data.otot > MinMtu) ev[12] = 1'b1;
          if (q_data.proto == 8'd6 || q_data.proto == 8'd17) begin
            r.orig_ports_valid = 1'b1;
            r.orig_src_port = q_data.ports[31:16];
            r.orig_dst_port = q_data.ports[15:0];
          end
        end
      end
      pay = q_data.len - {12'd0, hl};
      if (pay == 16'd0 && t == 8'd8) ev[15] = 1'b1;
      if (pay == 16'd0 && seq == EnumSeq) ev[16] = 1'b1;
      if (t == 8'd5 && c == 8'd1) ev[17] = 1'b1;
      if (t == 8'd5 && c == 8'd0) ev[18] = 1'b1;
      if (t == 8'd0 && q_data.rr) ev[19] = 1'b1;
      if (t == 8'd4 && c == 8'd0) ev[20] = 1'b1;
      if (pay == 16'd4 && t == 8'd8 && seq == 16'd0 && c == 8'd0) ev[21] = 1'b1;
      if (t == 8'd3 && c == 8'd13) ev[22] = 1'b1;
      if (t == 8'd3 && c == 8'd10) ev[23] = 1'b1;
      if (t == 8'd3 && c == 8'd9) ev[24] = 1'b1;
    end
    r.event_flags = ev & event_enable_mask;
    r.accepted = acc;
    r.header_len = hl;
    r.payload_len = pay;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (q_pop) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_item <= r;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.accepted == 1'b0) |-> out_item.orig_ports_valid == 1'b0)
    else $error("ports on truncated header");
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.accepted) |-> out_item.header_len == 4'd4 || out_item.header_len == 4'd8)
    else $error("bad header length");
endmodule

>>> rtl/icmp4_header_anomaly_checker.sv
// top level of the icmpv4 header anomaly checker
// uses icmp4_pkg, icmp4_front, icmp4_queue, icmp4_classify
//
// takes an icmpv4 message one byte per transfer, the outer ip side fields
// sampled with the last byte, and gives one result per message. a byte
// transfer can occur every cycle while in_stall is low: the front end folds each
// byte into the checksum and field captures, hands a message summary through
// a two-entry queue, and the decoder registers the result. output stalls back
// up through the queue only when it holds two pending messages.
module icmp4_header_anomaly_checker #(
  parameter int unsigned CfgIdxW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  icmp4_pkg::in_item_t  in_item,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output icmp4_pkg::out_item_t out_item,
  // register write port
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [24:0]          cfg_data
);
  import icmp4_pkg::*;

  // configuration registers
  logic [24:0] event_enable_mask;
  logic        checksum_check_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable_mask <= '1;
      checksum_check_enable <= 1'b1;
    end else if (cfg_we) begin
      // indexes beyond the register list are dropped
      if (cfg_index == CfgIdxW'(CfgMask)) event_enable_mask <= cfg_data;
      else if (cfg_index == CfgIdxW'(CfgCsum)) checksum_check_enable <= cfg_data[0];
    end
  end

  logic     q_full, q_valid, q_pop, sum_valid;
  msg_sum_t sum, q_data;

  // per-byte capture and checksum
  icmp4_front u_front (
    .clk, .rst, .in_valid, .in_item, .q_full, .in_stall, .sum_valid, .sum
  );

  // decouples the byte stream from the result side
  icmp4_queue u_queue (
    .clk, .rst, .wr_en(sum_valid), .wr_data(sum), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_pop), .rd_data(q_data)
  );

  // classification and output register
  icmp4_classify u_decode (
    .clk, .rst, .event_enable_mask, .checksum_check_enable,
    .q_valid, .q_data, .q_pop, .out_valid, .out_stall, .out_item
  );
endmodule
